@@ hw/rtl/tss_pkg.sv @@
// Shared types, constants and helpers for the ternary search table.
// Used by tss_engine and ternary_search_sorted_table; no dependencies.
`default_nettype none

package tss_pkg;

    // Table geometry and field widths
    localparam int TABLE_DEPTH = 1024;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = 10;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = ((ADDR_W > IDX_W) ? ADDR_W : IDX_W) + 2;

    // Divide by three: multiply by rounded-up reciprocal, then shift.
    // Exact for every operand below twice the table depth.
    localparam int RECIP_SHIFT = ADDR_W + 1;
    localparam int RECIP       = ((2 ** RECIP_SHIFT) + 2) / 3;
    localparam int PROD_W      = ADDR_W + RECIP_SHIFT;

    typedef logic [ADDR_W-1:0]             addr_t;
    typedef logic [IDX_W-1:0]              idx_t;
    typedef logic signed [VALUE_WIDTH-1:0] value_t;
    typedef logic signed [POS_W-1:0]       pos_t;

    // Request action codes
    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    // Search sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_CMP
    } state_t;

    // Table port controls from the sequencer
    typedef struct packed {
        logic   we;
        addr_t  waddr;
        value_t wdata;
        logic   re;
        addr_t  raddr_a;
        addr_t  raddr_b;
    } mem_req_t;

    // One search result
    typedef struct packed {
        logic found;
        idx_t index;
    } result_t;

    // Table index to signed range position
    function automatic pos_t to_pos(input addr_t a);
        return pos_t'({{(POS_W - ADDR_W){1'b0}}, a});
    endfunction

    // floor(d / 3)
    function automatic addr_t div3(input addr_t d);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(d) * PROD_W'(RECIP);
        return addr_t'(prod >> RECIP_SHIFT);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/tss_ram.sv @@
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module tss_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [WIDTH-1:0]  rdata_a,
    output logic      [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/tss_engine.sv @@
// Search sequencer: takes requests, drives the table RAM, runs ternary rounds.
// Depends on tss_pkg.
`default_nettype none

module tss_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic              action,
    input  wire tss_pkg::idx_t     entry_index,
    input  wire tss_pkg::value_t   entry_value,
    input  wire tss_pkg::idx_t     range_low,
    input  wire tss_pkg::idx_t     range_high,
    input  wire tss_pkg::value_t   target,
    output tss_pkg::mem_req_t      mem_req,
    input  wire tss_pkg::value_t   rdata_a,
    input  wire tss_pkg::value_t   rdata_b,
    input  wire logic              slot_free,
    output logic                   done,
    output tss_pkg::result_t       result
);

    import tss_pkg::*;

    state_t state_reg, state_next;
    pos_t   lo_reg, lo_next;
    pos_t   hi_reg, hi_next;
    value_t key_reg, key_next;
    addr_t  p1_reg, p1_next;
    addr_t  p2_reg, p2_next;

    logic   accept;
    logic   [POS_W-1:0] high_ext;
    addr_t  diff;
    addr_t  third;
    addr_t  p1;
    addr_t  p2;

    assign accept   = req_valid && req_ready;
    assign high_ext = POS_W'(range_high);

    // Probe points for the current range
    assign diff  = addr_t'(hi_reg - lo_reg);
    assign third = div3(diff);
    assign p1    = addr_t'(lo_reg) + third;
    assign p2    = addr_t'(hi_reg) - third;

    // State and round registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        key_reg <= key_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        key_next   = key_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        req_ready  = 1'b0;
        done       = 1'b0;
        result     = '0;

        mem_req         = '0;
        mem_req.waddr   = addr_t'(entry_index);
        mem_req.wdata   = entry_value;
        mem_req.raddr_a = p1;
        mem_req.raddr_b = p2;

        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (accept)
                begin
                    if (action == ACT_WRITE)
                    begin
                        // indexes past the table are dropped
                        mem_req.we = (POS_W'(entry_index) < POS_W'(TABLE_DEPTH));
                    end
                    else
                    begin
                        lo_next  = pos_t'(POS_W'(range_low));
                        key_next = target;
                        if (high_ext > POS_W'(TABLE_DEPTH - 1))
                        begin
                            hi_next = pos_t'(POS_W'(TABLE_DEPTH - 1));
                        end
                        else
                        begin
                            hi_next = pos_t'(high_ext);
                        end
                        state_next = ST_CALC;
                    end
                end
            end

            ST_CALC:
            begin
                if (lo_reg > hi_reg)
                begin
                    // empty range: miss
                    done = 1'b1;
                    if (slot_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mem_req.re = 1'b1;
                    p1_next    = p1;
                    p2_next    = p2;
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                if (rdata_a == key_reg)
                begin
                    done         = 1'b1;
                    result.found = 1'b1;
                    result.index = idx_t'(p1_reg);
                    if (slot_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else if (rdata_b == key_reg)
                begin
                    done         = 1'b1;
                    result.found = 1'b1;
                    result.index = idx_t'(p2_reg);
                    if (slot_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    // narrow to lower, upper or middle third
                    if (key_reg < rdata_a)
                    begin
                        hi_next = to_pos(p1_reg) - pos_t'(1);
                    end
                    else if (key_reg > rdata_b)
                    begin
                        lo_next = to_pos(p2_reg) + pos_t'(1);
                    end
                    else
                    begin
                        lo_next = to_pos(p1_reg) + pos_t'(1);
                        hi_next = to_pos(p2_reg) - pos_t'(1);
                    end
                    state_next = ST_CALC;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/ternary_search_sorted_table.sv @@
// Top level of the ternary search table: sequencer, table RAM, result register.
// Depends on tss_pkg, tss_ram and tss_engine.
`default_nettype none

// A request with action 0 writes entry_value to table entry entry_index and
// gives no response; an index past the table is ignored. A request with
// action 1 searches the inclusive range range_low..range_high (range_high
// clamped to the last entry) for target and gives one response: found and
// found_index, or found 0 and index 0 on a miss or an empty range. Each search
// round first computes the two probe points and reads both from the dual-read
// table RAM, then compares. A miss ends with a closing check that finds the
// range empty; over 1024 entries a search runs at most seven rounds. One
// request is in work at a time, but a new request is taken while the previous
// response waits for rsp_ready. Entries that were never written read as
// unknown data.
module ternary_search_sorted_table (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire logic              action,
    input  wire tss_pkg::idx_t     entry_index,
    input  wire tss_pkg::value_t   entry_value,
    input  wire tss_pkg::idx_t     range_low,
    input  wire tss_pkg::idx_t     range_high,
    input  wire tss_pkg::value_t   target,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output logic                   found,
    output tss_pkg::idx_t          found_index
);

    import tss_pkg::*;

    mem_req_t mem_req;
    value_t   rdata_a;
    value_t   rdata_b;
    logic     slot_free;
    logic     done;
    result_t  result;

    logic     rsp_valid_reg, rsp_valid_next;
    result_t  rsp_reg, rsp_next;

    tss_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .action      (action),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .range_low   (range_low),
        .range_high  (range_high),
        .target      (target),
        .mem_req     (mem_req),
        .rdata_a     (rdata_a),
        .rdata_b     (rdata_b),
        .slot_free   (slot_free),
        .done        (done),
        .result      (result)
    );

    tss_ram #(
        .DEPTH  (TABLE_DEPTH),
        .WIDTH  (VALUE_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .we      (mem_req.we),
        .waddr   (mem_req.waddr),
        .wdata   (mem_req.wdata),
        .re      (mem_req.re),
        .raddr_a (mem_req.raddr_a),
        .raddr_b (mem_req.raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    // Response register: free when empty or being taken
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (slot_free)
        begin
            rsp_valid_next = done;
            if (done)
            begin
                rsp_next = result;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign found       = rsp_reg.found;
    assign found_index = rsp_reg.index;

endmodule

`default_nettype wire

@@ tb/sv/ternary_search_sorted_table_tb.sv @@
// Self-checking testbench for the ternary search table: directed rows, then sorted runs
// with queries, random writes and queries, checked by a predictor or fixed answers.
// Depends on tss_pkg and ternary_search_sorted_table.
`timescale 1ns / 1ps

module ternary_search_sorted_table_tb;

    import tss_pkg::*;

    localparam int N_DIRECTED     = 24;
    localparam int ITEM_TARGET    = 750;
    localparam int PAUSE_AT       = 450;
    localparam int HOLD_AT        = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int TAIL_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SHOW_LIMIT     = 10;

    localparam value_t  VMIN   = value_t'(32'h8000_0000);
    localparam value_t  VMAX   = value_t'(32'h7FFF_FFFF);
    localparam result_t NO_HIT = '{found: 1'b0, index: '0};

    // One request as the sender sees it, with an optional hand-written answer
    typedef struct packed {
        action_t act;
        idx_t    eidx;
        value_t  eval;
        idx_t    lo;
        idx_t    hi;
        value_t  key;
        logic    fixed;
        result_t fixed_rsp;
    } request_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    req_valid;
    logic    req_ready;
    logic    action;
    idx_t    entry_index;
    value_t  entry_value;
    idx_t    range_low;
    idx_t    range_high;
    value_t  target;
    logic    rsp_valid;
    logic    rsp_ready;
    logic    found;
    idx_t    found_index;

    // Hand-written answer that travels with the request on the bus
    logic    fixed_answer_en;
    result_t fixed_answer;

    // Table as accepted by the block, and as planned by the generator
    value_t  table_model [TABLE_DEPTH];
    value_t  table_plan [TABLE_DEPTH];
    bit      plan_written [TABLE_DEPTH];

    result_t expected_answers [$];
    int      mismatch_count = 0;
    int      accepted_count = 0;
    int      sent = 0;
    int      burst_left = 0;
    int      idle_cycles = 0;
    bit      hold_done = 1'b0;

    request_t directed_rows [N_DIRECTED] = '{
        // empty ranges right after reset
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd5, 10'd4, 32'sd0, 1'b1, NO_HIT},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd1023, 10'd0, 32'sd0, 1'b1, NO_HIT},
        // small sorted block spanning the value extremes
        '{ACT_WRITE, 10'd0, VMIN, 10'd0, 10'd0, 32'sd0, 1'b0, NO_HIT},
        '{ACT_WRITE, 10'd1, value_t'(-1), 10'd0, 10'd0, 32'sd0, 1'b0, NO_HIT},
        '{ACT_WRITE, 10'd2, 32'sd0, 10'd0, 10'd0, 32'sd0, 1'b0, NO_HIT},
        '{ACT_WRITE, 10'd3, 32'sd1, 10'd0, 10'd0, 32'sd0, 1'b0, NO_HIT},
        '{ACT_WRITE, 10'd4, VMAX, 10'd0, 10'd0, 32'sd0, 1'b0, NO_HIT},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd0, 10'd0, VMIN, 1'b1, '{1'b1, 10'd0}},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd0, 10'd4, VMAX, 1'b0, NO_HIT},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd0, 10'd4, value_t'(-1), 1'b0, NO_HIT},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd0, 10'd4, 32'sd1, 1'b0, NO_HIT},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd0, 10'd4, 32'sd0, 1'b0, NO_HIT},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd0, 10'd4, VMIN, 1'b0, NO_HIT},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd0, 10'd4, 32'sd5, 1'b0, NO_HIT},
        // duplicates at the top of the table: first probe wins
        '{ACT_WRITE, 10'd1023, 32'sd7, 10'd0, 10'd0, 32'sd0, 1'b0, NO_HIT},
        '{ACT_WRITE, 10'd1022, 32'sd7, 10'd0, 10'd0, 32'sd0, 1'b0, NO_HIT},
        '{ACT_WRITE, 10'd1021, 32'sd3, 10'd0, 10'd0, 32'sd0, 1'b0, NO_HIT},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd1022, 10'd1023, 32'sd7, 1'b0, NO_HIT},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd1021, 10'd1023, 32'sd7, 1'b0, NO_HIT},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd1023, 10'd1023, 32'sd7, 1'b1, '{1'b1, 10'd1023}},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd1023, 10'd1023, 32'sd8, 1'b1, NO_HIT},
        // unsorted range
        '{ACT_WRITE, 10'd5, 32'sd100, 10'd0, 10'd0, 32'sd0, 1'b0, NO_HIT},
        '{ACT_WRITE, 10'd6, value_t'(-100), 10'd0, 10'd0, 32'sd0, 1'b0, NO_HIT},
        '{ACT_QUERY, 10'd0, 32'sd0, 10'd0, 10'd6, value_t'(-100), 1'b0, NO_HIT}
    };

    ternary_search_sorted_table u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .action      (action),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .range_low   (range_low),
        .range_high  (range_high),
        .target      (target),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .found       (found),
        .found_index (found_index)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Ternary search over the accepted or the planned table.
    // Returns 1 when a probe lands on an entry not yet written (planned table only).
    function automatic bit ternary_lookup(input bit on_plan, input idx_t lo_in, input idx_t hi_in,
                                          input value_t key, output result_t res);
        int     lo;
        int     hi;
        int     third;
        int     p1;
        int     p2;
        value_t v1;
        value_t v2;
        bit     blind;
        bit     done;
        lo    = int'(lo_in);
        hi    = int'(hi_in);
        res   = NO_HIT;
        blind = 1'b0;
        done  = 1'b0;
        if (hi > TABLE_DEPTH - 1)
            hi = TABLE_DEPTH - 1;
        while (!done && lo <= hi)
        begin
            third = (hi - lo) / 3;
            p1    = lo + third;
            p2    = hi - third;
            if (on_plan)
            begin
                v1 = table_plan[p1];
                v2 = table_plan[p2];
                if (!plan_written[p1] || !plan_written[p2])
                    blind = 1'b1;
            end
            else
            begin
                v1 = table_model[p1];
                v2 = table_model[p2];
            end
            if (v1 == key)
            begin
                res  = '{found: 1'b1, index: idx_t'(p1)};
                done = 1'b1;
            end
            else if (v2 == key)
            begin
                res  = '{found: 1'b1, index: idx_t'(p2)};
                done = 1'b1;
            end
            else if (key < v1)
                hi = p1 - 1;
            else if (key > v2)
                lo = p2 + 1;
            else
            begin
                lo = p1 + 1;
                hi = p2 - 1;
            end
        end
        return blind;
    endfunction

    function automatic void report_mismatch(input string why, input result_t want,
                                            input logic got_found, input idx_t got_index);
        mismatch_count++;
        if (mismatch_count <= SHOW_LIMIT)
            $display("%0t: %s: expected found=%0b index=%0d, got found=%0b index=%0d",
                     $realtime, why, want.found, want.index, got_found, got_index);
    endfunction

    // Drive one request at the falling edge, bursts and gaps on the sender side
    task automatic send_request(input request_t r);
        int gap;
        if (r.act == ACT_WRITE)
        begin
            r.lo  = idx_t'($urandom);
            r.hi  = idx_t'($urandom);
            r.key = value_t'($urandom);
            table_plan[r.eidx]   = r.eval;
            plan_written[r.eidx] = 1'b1;
        end
        else
        begin
            r.eidx = idx_t'($urandom);
            r.eval = value_t'($urandom);
        end
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        req_valid       <= 1'b1;
        action          <= r.act;
        entry_index     <= r.eidx;
        entry_value     <= r.eval;
        range_low       <= r.lo;
        range_high      <= r.hi;
        target          <= r.key;
        fixed_answer_en <= r.fixed;
        fixed_answer    <= r.fixed_rsp;
        do
            @(posedge clk);
        while (!req_ready);
        sent++;
    endtask

    task automatic send_write(input idx_t idx, input value_t val);
        send_request('{ACT_WRITE, idx, val, 10'd0, 10'd0, 32'sd0, 1'b0, NO_HIT});
    endtask

    // A query that would touch an unwritten entry becomes an empty range instead
    task automatic send_query(input idx_t lo, input idx_t hi, input value_t key);
        result_t dummy;
        if (ternary_lookup(1'b1, lo, hi, key, dummy))
        begin
            lo = idx_t'($urandom_range(1, TABLE_DEPTH - 1));
            hi = idx_t'($urandom_range(0, int'(lo) - 1));
        end
        send_request('{ACT_QUERY, 10'd0, 32'sd0, lo, hi, key, 1'b0, NO_HIT});
    endtask

    task automatic wait_all_answered();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge clk);
    endtask

    // Response checker and predictor, both at the rising edge
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (expected_answers.size() == 0)
                    report_mismatch("response with no request pending", NO_HIT,
                                    found, found_index);
                else
                begin
                    want = expected_answers.pop_front();
                    if (found !== want.found || found_index !== want.index)
                        report_mismatch("response mismatch", want, found, found_index);
                end
            end
            if (req_valid && req_ready)
            begin
                accepted_count++;
                if (action == ACT_WRITE)
                    table_model[entry_index] = entry_value;
                else if (fixed_answer_en)
                    expected_answers.push_back(fixed_answer);
                else
                begin
                    void'(ternary_lookup(1'b0, range_low, range_high, target, want));
                    expected_answers.push_back(want);
                end
            end
        end
    end

    // Watchdog: cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("ternary_search_sorted_table_tb NOT OK");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver: stall pattern changes per segment, one long hold-off
    initial
    begin
        int mode;
        int seg;
        int cyc;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(20, 200);
            for (cyc = 0; cyc < seg; cyc++)
            begin
                @(negedge clk);
                if (!hold_done && accepted_count >= HOLD_AT)
                begin
                    rsp_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(negedge clk);
                    hold_done = 1'b1;
                end
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= ($urandom_range(0, 1) == 1);
                    2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= ((cyc % 5) >= 2);
                endcase
            end
        end
    end

    // Sender: directed rows, then sorted runs, random writes and random queries
    initial
    begin
        int     i;
        int     k;
        int     len;
        int     s;
        int     nq;
        int     a;
        int     b;
        int     pick;
        int     vmode;
        int     base;
        int     run_vals [$];
        bit     paused;
        value_t key;

        paused          = 1'b0;
        req_valid       = 1'b0;
        action          = ACT_WRITE;
        entry_index     = '0;
        entry_value     = '0;
        range_low       = '0;
        range_high      = '0;
        target          = '0;
        fixed_answer_en = 1'b0;
        fixed_answer    = NO_HIT;
        for (i = 0; i < TABLE_DEPTH; i++)
            plan_written[i] = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++)
            send_request(directed_rows[i]);

        while (sent < ITEM_TARGET)
        begin
            if (!paused && sent >= PAUSE_AT)
            begin
                wait_all_answered();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                // sorted run written in place, then queries inside it or over empty ranges
                len   = ($urandom_range(0, 6) == 0) ? $urandom_range(25, 120)
                                                    : $urandom_range(1, 24);
                s     = $urandom_range(0, TABLE_DEPTH - len);
                vmode = $urandom_range(0, 2);
                base  = $urandom;
                run_vals.delete();
                for (k = 0; k < len; k++)
                begin
                    case (vmode)
                        0:       run_vals.push_back($urandom);
                        1:       run_vals.push_back(base + int'($urandom_range(0, 2 * len)));
                        default: run_vals.push_back(int'($urandom_range(0, 16)) - 8);
                    endcase
                end
                run_vals.sort();
                for (k = 0; k < len; k++)
                    send_write(idx_t'(s + k), value_t'(run_vals[k]));
                nq = $urandom_range(3, 10);
                for (k = 0; k < nq; k++)
                begin
                    a = $urandom_range(s, s + len - 1);
                    b = $urandom_range(a, s + len - 1);
                    case ($urandom_range(0, 5))
                        0, 1, 2: key = table_plan[$urandom_range(a, b)];
                        3:       key = table_plan[$urandom_range(a, b)]
                                       + value_t'(($urandom_range(0, 1) == 1) ? 1 : -1);
                        4:       key = value_t'($urandom);
                        default:
                        begin
                            // empty range
                            a   = $urandom_range(1, TABLE_DEPTH - 1);
                            b   = $urandom_range(0, a - 1);
                            key = value_t'($urandom);
                        end
                    endcase
                    send_query(idx_t'(a), idx_t'(b), key);
                end
            end
            else if (pick < 85)
            begin
                // scattered writes, may break the ordering
                nq = $urandom_range(1, 4);
                for (k = 0; k < nq; k++)
                    send_write(idx_t'($urandom), value_t'($urandom));
            end
            else
            begin
                // queries over arbitrary ranges
                nq = $urandom_range(1, 3);
                for (k = 0; k < nq; k++)
                begin
                    a = $urandom_range(0, TABLE_DEPTH - 1);
                    if ($urandom_range(0, 4) == 0)
                        b = $urandom_range(0, TABLE_DEPTH - 1);
                    else
                        b = (a + $urandom_range(0, 40) > TABLE_DEPTH - 1)
                            ? TABLE_DEPTH - 1 : a + $urandom_range(0, 40);
                    key = (plan_written[a] && $urandom_range(0, 1) == 1)
                          ? table_plan[a] : value_t'($urandom);
                    send_query(idx_t'(a), idx_t'(b), key);
                end
            end
        end

        wait_all_answered();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_answers.size() == 0)
            $display("ternary_search_sorted_table_tb OK");
        else
            $display("ternary_search_sorted_table_tb NOT OK");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/tss_pkg.sv
hw/rtl/tss_ram.sv
hw/rtl/tss_engine.sv
hw/rtl/ternary_search_sorted_table.sv
tb/sv/ternary_search_sorted_table_tb.sv
